>>> hw/rtl/slt_pkg.sv
// Shared types, codes and decode helpers for the string literal transcoder.
// Used by the front decoder, the result queue and the top level.
`timescale 1ns / 1ps

package slt_pkg;

	// unit_mode encodings (3 behaves as 2)
	localparam logic [1:0] MODE_RAW   = 2'd0;
	localparam logic [1:0] MODE_UTF16 = 2'd1;
	localparam logic [1:0] MODE_UTF32 = 2'd2;

	// error codes reported on the done result
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_HEX_EMPTY = 2'd1;
	localparam logic [1:0] ERR_BAD_UTF8  = 2'd2;
	localparam logic [1:0] ERR_TRUNC     = 2'd3;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_X         = 8'h78;

	localparam logic [31:0] SUPP_BASE   = 32'h0001_0000;
	localparam logic [31:0] SURR_HI     = 32'h0000_D800;
	localparam logic [31:0] SURR_LO     = 32'h0000_DC00;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [1:0] mode_t;

	typedef struct packed {
		logic [31:0] code_unit;
		logic        unit_valid;
		logic        literal_done;
		logic [1:0]  error_code;
	} item_t;

	// up to two results written into the queue in one cycle
	typedef struct packed {
		logic [1:0] num;
		item_t      item0;
		item_t      item1;
	} push_req_t;

	function automatic logic [31:0] mask_unit(logic [31:0] v, mode_t m);
		logic [31:0] r;
		r = v;
		if (m == MODE_RAW) begin
			r = {24'd0, v[7:0]};
		end else if (m == MODE_UTF16) begin
			r = {16'd0, v[15:0]};
		end
		return r;
	endfunction

	function automatic item_t unit_item(logic [31:0] v, mode_t m);
		item_t it;
		it.code_unit    = mask_unit(v, m);
		it.unit_valid   = 1'b1;
		it.literal_done = 1'b0;
		it.error_code   = ERR_NONE;
		return it;
	endfunction

	function automatic logic [7:0] named_escape(logic [7:0] b);
		logic [7:0] r;
		case (b)
			8'h61: r = 8'd7;   // a
			8'h62: r = 8'd8;   // b
			8'h74: r = 8'd9;   // t
			8'h6E: r = 8'd10;  // n
			8'h76: r = 8'd11;  // v
			8'h66: r = 8'd12;  // f
			8'h72: r = 8'd13;  // r
			8'h65: r = 8'd27;  // e
			default: r = b;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] keep_first(logic [1:0] cur, logic [1:0] e);
		return (cur == ERR_NONE) ? e : cur;
	endfunction

endpackage

>>> hw/rtl/string_literal_transcoder_core.sv
// Top level of the string literal transcoder: mode register, front decoder
// and result queue. Depends on slt_pkg, slt_front and slt_queue.
`timescale 1ns / 1ps

// Usage
//   s_axis: one literal body byte per request in tdata; tlast marks the end
//     request, which carries no byte and closes the literal.
//   m_axis: up to two results per request. tdata has the code unit and error
//     code, tuser says whether a unit is carried, tlast marks the done
//     result that ends each literal and reports its first error.
//   cfg: write unit_mode (0 bytes, 1 UTF-16, 2 or 3 UTF-32) while idle.
// Output: a result is written into the queue when its input is taken and
//   shows on m_axis once it heads the queue. Throughput: one input byte
//   per cycle while s_axis_tready is high. A byte that yields two results
//   (a closed escape then a unit, or a surrogate pair) writes both at once;
//   the output drains one result per cycle from a four-entry queue.
// Stall: when m_axis_tready is low the queue fills; s_axis_tready drops
//   while fewer than two entries are free, so nothing is lost.
// Reset: arst_n clears the decode state, the queue and unit_mode (to 0).

module string_literal_transcoder_core (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  logic        s_axis_tlast,   // end_marker
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] code_unit, [33:32] error_code, zero pad
	output logic        m_axis_tuser,   // [0] unit_valid
	output logic        m_axis_tlast,   // literal_done
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data        // unit_mode
);
	import slt_pkg::*;

	mode_t     unit_mode_q;
	push_req_t push;
	logic      space_ok;
	item_t     head;

	// register is always writable; the user writes it only while idle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_mode_q <= MODE_RAW;
		end else if (cfg_valid && cfg_ready) begin
			unit_mode_q <= cfg_data;
		end
	end

	// decode each byte and push its results
	slt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.space_ok   (space_ok),
		.text_byte  (s_axis_tdata),
		.end_marker (s_axis_tlast),
		.unit_mode  (unit_mode_q),
		.in_ready   (s_axis_tready),
		.push       (push)
	);

	// hold results until the receiver takes them
	slt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space_ok  (space_ok),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (head)
	);

	assign m_axis_tdata = {6'd0, head.error_code, head.code_unit};
	assign m_axis_tuser = head.unit_valid;
	assign m_axis_tlast = head.literal_done;

endmodule

>>> hw/rtl/slt_front.sv
// Front decoder: accepts literal bytes, runs the escape / UTF-8 state and
// hands up to two results per byte to the queue. Depends on slt_pkg.
`timescale 1ns / 1ps

module slt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              space_ok,
	input  logic [7:0]        text_byte,
	input  logic              end_marker,
	input  slt_pkg::mode_t    unit_mode,
	output logic              in_ready,
	output slt_pkg::push_req_t push
);
	import slt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ESC,
		ST_OCT,
		ST_HEX,
		ST_UTF
	} dec_state_t;

	dec_state_t  st_q, st_n;
	logic [31:0] val_q, val_n;
	logic [1:0]  cnt_q, cnt_n;
	logic [1:0]  left_q, left_n;
	logic [1:0]  err_q, err_n;

	logic        accept;
	logic        is_oct, hex_ok, is_cont;
	logic [3:0]  hex_val;
	logic        pre_v, post0_v, post1_v, run_idle;
	item_t       pre_it, post0_it, post1_it;
	logic [31:0] cp, cp_off;

	assign in_ready = space_ok;
	assign accept   = in_valid & space_ok;

	assign is_oct  = text_byte inside {[8'h30:8'h37]};
	assign is_cont = (text_byte[7:6] == 2'b10);

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (text_byte inside {[8'h30:8'h39]}) begin
			hex_val = 4'(text_byte - 8'h30);
		end else if (text_byte inside {[8'h61:8'h66]}) begin
			hex_val = 4'(text_byte - 8'h57);
		end else if (text_byte inside {[8'h41:8'h46]}) begin
			hex_val = 4'(text_byte - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	always_comb begin
		st_n     = st_q;
		val_n    = val_q;
		cnt_n    = cnt_q;
		left_n   = left_q;
		err_n    = err_q;
		pre_v    = 1'b0;
		post0_v  = 1'b0;
		post1_v  = 1'b0;
		run_idle = 1'b0;
		pre_it   = unit_item(val_q, unit_mode);
		post0_it = unit_item({24'd0, text_byte}, unit_mode);
		post1_it = unit_item(32'd0, unit_mode);
		cp       = 32'd0;
		cp_off   = 32'd0;

		if (end_marker) begin
			case (st_q)
				ST_OCT: pre_v = 1'b1;
				ST_HEX: begin
					if (cnt_q == 2'd0) begin
						err_n = keep_first(err_n, ERR_HEX_EMPTY);
					end else begin
						pre_v = 1'b1;
					end
				end
				ST_ESC, ST_UTF: err_n = keep_first(err_n, ERR_TRUNC);
				default: ;
			endcase
			post0_v               = 1'b1;
			post0_it.code_unit    = 32'd0;
			post0_it.unit_valid   = 1'b0;
			post0_it.literal_done = 1'b1;
			post0_it.error_code   = err_n;
			// back to reset for the next literal
			st_n   = ST_IDLE;
			val_n  = 32'd0;
			cnt_n  = 2'd0;
			left_n = 2'd0;
			err_n  = ERR_NONE;
		end else begin
			case (st_q)
				ST_ESC: begin
					if (is_oct) begin
						val_n = {29'd0, text_byte[2:0]};
						cnt_n = 2'd1;
						st_n  = ST_OCT;
					end else if (text_byte == CH_X) begin
						val_n = 32'd0;
						cnt_n = 2'd0;
						st_n  = ST_HEX;
					end else begin
						post0_v  = 1'b1;
						post0_it = unit_item({24'd0, named_escape(text_byte)}, unit_mode);
						st_n     = ST_IDLE;
					end
				end
				ST_OCT: begin
					if (is_oct) begin
						val_n = {val_q[28:0], text_byte[2:0]};
						cnt_n = cnt_q + 2'd1;
						if (cnt_n == 2'd3) begin
							pre_v  = 1'b1;
							pre_it = unit_item(val_n, unit_mode);
							st_n   = ST_IDLE;
							cnt_n  = 2'd0;
						end
					end else begin
						pre_v    = 1'b1;
						cnt_n    = 2'd0;
						run_idle = 1'b1;
					end
				end
				ST_HEX: begin
					if (hex_ok) begin
						val_n = {val_q[27:0], hex_val};
						cnt_n = 2'd1;
					end else begin
						if (cnt_q == 2'd0) begin
							err_n = keep_first(err_n, ERR_HEX_EMPTY);
						end else begin
							pre_v = 1'b1;
						end
						cnt_n    = 2'd0;
						run_idle = 1'b1;
					end
				end
				ST_UTF: begin
					if (is_cont) begin
						val_n  = {val_q[25:0], text_byte[5:0]};
						left_n = left_q - 2'd1;
						if (left_n == 2'd0) begin
							st_n    = ST_IDLE;
							cp      = val_n;
							post0_v = 1'b1;
							if (unit_mode == MODE_UTF16 && cp >= SUPP_BASE) begin
								cp_off   = cp - SUPP_BASE;
								post1_v  = 1'b1;
								post0_it = unit_item(SURR_HI + {22'd0, cp_off[19:10]}, unit_mode);
								post1_it = unit_item(SURR_LO + {22'd0, cp_off[9:0]}, unit_mode);
							end else begin
								post0_it = unit_item(cp, unit_mode);
							end
						end
					end else begin
						err_n    = keep_first(err_n, ERR_BAD_UTF8);
						left_n   = 2'd0;
						run_idle = 1'b1;
					end
				end
				default: run_idle = 1'b1;
			endcase

			if (run_idle) begin
				st_n = ST_IDLE;
				if (text_byte == CH_BACKSLASH) begin
					st_n = ST_ESC;
				end else if (unit_mode == MODE_RAW || !text_byte[7]) begin
					post0_v  = 1'b1;
					post0_it = unit_item({24'd0, text_byte}, unit_mode);
				end else if (text_byte >= 8'hF0) begin
					val_n  = {29'd0, text_byte[2:0]};
					left_n = 2'd3;
					st_n   = ST_UTF;
				end else if (text_byte >= 8'hE0) begin
					val_n  = {28'd0, text_byte[3:0]};
					left_n = 2'd2;
					st_n   = ST_UTF;
				end else if (text_byte >= 8'hC0) begin
					val_n  = {27'd0, text_byte[4:0]};
					left_n = 2'd1;
					st_n   = ST_UTF;
				end else begin
					err_n = keep_first(err_n, ERR_BAD_UTF8);
				end
			end
		end
	end

	// pack results: a closing escape unit always goes first
	always_comb begin
		push.num   = 2'd0;
		push.item0 = post0_it;
		push.item1 = post1_it;
		if (accept) begin
			if (pre_v) begin
				push.item0 = pre_it;
				push.item1 = post0_it;
				push.num   = post0_v ? 2'd2 : 2'd1;
			end else if (post0_v) begin
				push.num = post1_v ? 2'd2 : 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			val_q  <= 32'd0;
			cnt_q  <= 2'd0;
			left_q <= 2'd0;
			err_q  <= ERR_NONE;
		end else if (accept) begin
			st_q   <= st_n;
			val_q  <= val_n;
			cnt_q  <= cnt_n;
			left_q <= left_n;
			err_q  <= err_n;
		end
	end

endmodule

>>> hw/rtl/slt_queue.sv
// Result queue between decoder and output: two writes, one read per cycle.
// The head entry drives the output channel directly. Depends on slt_pkg.
`timescale 1ns / 1ps

module slt_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  slt_pkg::push_req_t push,
	output logic               space_ok,
	output logic               out_valid,
	input  logic               out_ready,
	output slt_pkg::item_t     out_item
);
	import slt_pkg::*;

	item_t               mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                pop;
	logic [QPTR_W-1:0]   wr_ptr_1;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid & out_ready;
	assign out_item  = mem[rd_ptr_q];
	assign wr_ptr_1  = wr_ptr_q + QPTR_W'(1);
	// room for the worst case of two results
	assign space_ok  = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem[wr_ptr_q] <= push.item0;
		end
		if (push.num == 2'd2) begin
			mem[wr_ptr_1] <= push.item1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.num);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push.num) - QCNT_W'(pop);
		end
	end

endmodule

>>> hw/rtl/slt_checker.sv
// Port-level checks for string_literal_transcoder_core, attached by bind.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module slt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// a done result carries no unit
	a_done_bare: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
			!m_axis_tuser && m_axis_tdata[31:0] == 32'd0)
		else $error("done result carries a unit");

	// every other result is a unit with no error
	a_unit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |->
			m_axis_tuser && m_axis_tdata[33:32] == 2'd0)
		else $error("unit result malformed");

	// padding stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39:34] == 6'd0)
		else $error("tdata padding not zero");

endmodule

bind string_literal_transcoder_core slt_checker u_slt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

>>> sim/slt_result_checker.sv
`timescale 1ns / 1ps
// Result checker for string_literal_transcoder_core: mirrors the escape and UTF-8
// decode for every accepted request and compares each accepted result with it.
// Depends on slt_pkg.

module slt_result_checker
	import slt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  logic        s_axis_tlast,   // end_marker
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,   // [31:0] code_unit, [33:32] error_code, zero pad
	input  logic        m_axis_tuser,   // [0] unit_valid
	input  logic        m_axis_tlast,   // literal_done
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_data,       // unit_mode
	output int          fail_count,
	output int          results_owed
);

	typedef enum logic [2:0] {DS_IDLE, DS_ESC, DS_OCT, DS_HEX, DS_UTF} dec_state_t;

	mode_t       mode_reg;
	dec_state_t  dstate;
	logic [31:0] partial;
	logic [1:0]  digits_seen;
	logic [1:0]  cont_left;
	logic [1:0]  err_first;
	item_t       expected_units [$];
	item_t       want;

	function automatic logic is_octal(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h37;
	endfunction

	// {hit, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39) begin
			return {1'b1, b[3:0]};
		end
		if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			return {1'b1, b[3:0] + 4'd9};
		end
		return 5'd0;
	endfunction

	function automatic logic [7:0] escape_letter(input logic [7:0] b);
		case (b)
			"a": return 8'd7;
			"b": return 8'd8;
			"t": return 8'd9;
			"n": return 8'd10;
			"v": return 8'd11;
			"f": return 8'd12;
			"r": return 8'd13;
			"e": return 8'd27;
			default: return b;
		endcase
	endfunction

	task automatic note_error(input logic [1:0] e);
		if (err_first == ERR_NONE) begin
			err_first = e;
		end
	endtask

	// mask by the mode in force now; mode 3 keeps all 32 bits like mode 2
	task automatic push_unit(input logic [31:0] v);
		item_t it;
		it.code_unit = v;
		if (mode_reg == MODE_RAW) begin
			it.code_unit = {24'd0, v[7:0]};
		end else if (mode_reg == MODE_UTF16) begin
			it.code_unit = {16'd0, v[15:0]};
		end
		it.unit_valid   = 1'b1;
		it.literal_done = 1'b0;
		it.error_code   = ERR_NONE;
		expected_units.push_back(it);
	endtask

	task automatic push_code_point(input logic [31:0] cp);
		logic [31:0] off;
		off = cp - SUPP_BASE;
		if (mode_reg == MODE_UTF16 && cp >= SUPP_BASE) begin
			push_unit(SURR_HI + {22'd0, off[19:10]});
			push_unit(SURR_LO + {22'd0, off[9:0]});
		end else begin
			push_unit(cp);
		end
	endtask

	task automatic restart_decode(input logic [7:0] b);
		dstate = DS_IDLE;
		if (b == CH_BACKSLASH) begin
			dstate = DS_ESC;
		end else if (mode_reg == MODE_RAW || !b[7]) begin
			push_unit({24'd0, b});
		end else if (b >= 8'hF0) begin
			partial   = {29'd0, b[2:0]};
			cont_left = 2'd3;
			dstate    = DS_UTF;
		end else if (b >= 8'hE0) begin
			partial   = {28'd0, b[3:0]};
			cont_left = 2'd2;
			dstate    = DS_UTF;
		end else if (b >= 8'hC0) begin
			partial   = {27'd0, b[4:0]};
			cont_left = 2'd1;
			dstate    = DS_UTF;
		end else begin
			note_error(ERR_BAD_UTF8);
		end
	endtask

	task automatic transcode_item(input logic [7:0] b, input logic is_end);
		logic [4:0] hx;
		item_t      done;
		hx = hex_digit(b);
		if (is_end) begin
			case (dstate)
				DS_OCT: push_unit(partial);
				DS_HEX: begin
					if (digits_seen == 2'd0) begin
						note_error(ERR_HEX_EMPTY);
					end else begin
						push_unit(partial);
					end
				end
				DS_ESC, DS_UTF: note_error(ERR_TRUNC);
				default: ;
			endcase
			done.code_unit    = 32'd0;
			done.unit_valid   = 1'b0;
			done.literal_done = 1'b1;
			done.error_code   = err_first;
			expected_units.push_back(done);
			dstate      = DS_IDLE;
			partial     = 32'd0;
			digits_seen = 2'd0;
			cont_left   = 2'd0;
			err_first   = ERR_NONE;
		end else begin
			case (dstate)
				DS_ESC: begin
					if (is_octal(b)) begin
						partial     = {29'd0, b[2:0]};
						digits_seen = 2'd1;
						dstate      = DS_OCT;
					end else if (b == CH_X) begin
						partial     = 32'd0;
						digits_seen = 2'd0;
						dstate      = DS_HEX;
					end else begin
						push_unit({24'd0, escape_letter(b)});
						dstate = DS_IDLE;
					end
				end
				DS_OCT: begin
					if (is_octal(b)) begin
						partial     = {partial[28:0], b[2:0]};
						digits_seen = digits_seen + 2'd1;
						if (digits_seen == 2'd3) begin
							push_unit(partial);
							dstate      = DS_IDLE;
							digits_seen = 2'd0;
						end
					end else begin
						// close the escape, then take the byte from idle
						push_unit(partial);
						digits_seen = 2'd0;
						restart_decode(b);
					end
				end
				DS_HEX: begin
					if (hx[4]) begin
						partial     = {partial[27:0], hx[3:0]};
						digits_seen = 2'd1;
					end else begin
						if (digits_seen == 2'd0) begin
							note_error(ERR_HEX_EMPTY);
						end else begin
							push_unit(partial);
						end
						digits_seen = 2'd0;
						restart_decode(b);
					end
				end
				DS_UTF: begin
					if (b[7:6] == 2'b10) begin
						partial   = {partial[25:0], b[5:0]};
						cont_left = cont_left - 2'd1;
						if (cont_left == 2'd0) begin
							dstate = DS_IDLE;
							push_code_point(partial);
						end
					end else begin
						// drop the broken sequence and start over on this byte
						note_error(ERR_BAD_UTF8);
						cont_left = 2'd0;
						restart_decode(b);
					end
				end
				default: restart_decode(b);
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_reg     = MODE_RAW;
			dstate       = DS_IDLE;
			partial      = 32'd0;
			digits_seen  = 2'd0;
			cont_left    = 2'd0;
			err_first    = ERR_NONE;
			fail_count   = 0;
			results_owed = 0;
			expected_units.delete();
		end else begin
			// compare before predicting: a request taken now cannot answer now
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_units.size() == 0) begin
					$error("unexpected result: code_unit %0h literal_done %0b",
						m_axis_tdata[31:0], m_axis_tlast);
					fail_count++;
				end else begin
					want = expected_units.pop_front();
					if (m_axis_tdata[31:0] !== want.code_unit) begin
						$error("code_unit mismatch: expected %0h, actual %0h",
							want.code_unit, m_axis_tdata[31:0]);
						fail_count++;
					end
					if (m_axis_tuser !== want.unit_valid) begin
						$error("unit_valid mismatch: expected %0b, actual %0b",
							want.unit_valid, m_axis_tuser);
						fail_count++;
					end
					if (m_axis_tlast !== want.literal_done) begin
						$error("literal_done mismatch: expected %0b, actual %0b",
							want.literal_done, m_axis_tlast);
						fail_count++;
					end
					if (m_axis_tdata[33:32] !== want.error_code) begin
						$error("error_code mismatch: expected %0d, actual %0d",
							want.error_code, m_axis_tdata[33:32]);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				mode_reg = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				transcode_item(s_axis_tdata, s_axis_tlast);
			end
			results_owed = expected_units.size();
		end
	end

endmodule

>>> sim/string_literal_transcoder_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for string_literal_transcoder_core: drives literal bytes, end
// requests and mode writes under random stalls, and gives the verdict.
// Depends on slt_pkg, the core and slt_result_checker.

module string_literal_transcoder_core_tb;
	import slt_pkg::*;

	localparam mode_t      MODE_UTF32_ALT = 2'd3;   // decodes as UTF-32
	localparam int         STALL_LIMIT    = 5000;
	localparam int         SEG_ITEMS      = 200;
	localparam int         NUM_SEGS       = 9;
	localparam int         SETTLE_CYCLES  = 4;
	localparam logic [8:0] END_ITEM       = 9'h100;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'd0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_data      = MODE_RAW;

	int fail_count;
	int results_owed;
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	int items_sent    = 0;
	int quiet_cycles  = 0;
	int target        = 0;

	mode_t seg_modes [0:NUM_SEGS-1] = '{MODE_RAW, MODE_UTF16, MODE_UTF32,
		MODE_UTF32_ALT, MODE_RAW, MODE_UTF16, MODE_UTF32, MODE_UTF32_ALT, MODE_UTF16};

	// UTF-16 mode: surrogate pair, octal, bad sequence; hex closed by a byte,
	// octal closed by a lead byte, truncated at end; backslash at end;
	// 0xF8..0xFF lead above 0x10FFFF and a zero byte
	logic [8:0] directed_seq [0:27] = '{
		9'h0F0, 9'h09F, 9'h098, 9'h080, 9'h05C, 9'h031, 9'h032, 9'h033,
		9'h0C3, 9'h041, END_ITEM,
		9'h05C, 9'h078, 9'h034, 9'h031, 9'h07A, 9'h05C, 9'h037, 9'h0E2, END_ITEM,
		9'h05C, END_ITEM,
		9'h0FF, 9'h080, 9'h080, 9'h080, 9'h000, END_ITEM
	};

	string letters = "abtnvfre";

	string_literal_transcoder_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	slt_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.results_owed  (results_owed)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// end the run when nothing moves on any channel for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("string_literal_transcoder_core_tb: FAIL");
			$finish;
		end
	end

	// hold valid across back-to-back requests; drop it only in a gap
	task automatic send_item(input logic [7:0] b, input logic is_end);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= is_end;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	// hold off input until every owed result is out and the core has settled
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input mode_t m);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// one literal: plain bytes, escapes, UTF-8 sequences, broken pieces, noise
	task automatic send_literal();
		int         kind;
		int         len;
		logic [7:0] b;
		logic [3:0] nib;
		repeat ($urandom_range(0, 10)) begin
			kind = $urandom_range(0, 99);
			if (kind < 25) begin
				b = 8'($urandom_range(0, 127));
				send_item((b == CH_BACKSLASH) ? 8'h20 : b, 1'b0);
			end else if (kind < 50) begin
				send_item(CH_BACKSLASH, 1'b0);
				case ($urandom_range(0, 3))
					0: send_item(letters[$urandom_range(0, 7)], 1'b0);
					1: begin
						repeat ($urandom_range(1, 3)) begin
							send_item(8'h30 + 8'($urandom_range(0, 7)), 1'b0);
						end
					end
					2: begin
						send_item(CH_X, 1'b0);
						repeat ($urandom_range(0, 9)) begin
							nib = 4'($urandom_range(0, 15));
							if (nib < 10) begin
								b = 8'h30 + nib;
							end else begin
								b = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
							end
							send_item(b, 1'b0);
						end
					end
					default: send_item(8'($urandom_range(0, 255)), 1'b0);
				endcase
			end else if (kind < 90) begin
				// well-formed sequence, or one cut short / a stray continuation
				len = $urandom_range(1, 4);
				case (len)
					1: b = 8'($urandom_range(0, 127));
					2: b = 8'hC0 | 8'($urandom_range(0, 31));
					3: b = 8'hE0 | 8'($urandom_range(0, 15));
					default: b = 8'hF0 | 8'($urandom_range(0, 15));
				endcase
				if (kind >= 80) begin
					if (len == 1) begin
						b = 8'h80 | 8'($urandom_range(0, 63));
					end else begin
						len = $urandom_range(1, len - 1);
					end
				end
				send_item(b, 1'b0);
				repeat (len - 1) send_item(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
			end else begin
				send_item(8'($urandom_range(0, 255)), 1'b0);
			end
		end
		if ($urandom_range(0, 9) == 0) begin
			send_item(CH_BACKSLASH, 1'b0);
		end
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct  = 19;
		sink_idle_pct = 72;
		write_mode(MODE_UTF16);
		foreach (directed_seq[i]) begin
			send_item(directed_seq[i][7:0], directed_seq[i][8]);
		end

		target = items_sent;
		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			if (seg < 3) begin
				src_idle_pct  = 19;
				sink_idle_pct = 72;
			end else if (seg < 6) begin
				src_idle_pct  = 72;
				sink_idle_pct = 19;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			write_mode(seg_modes[seg]);
			target += SEG_ITEMS;
			while (items_sent < target) begin
				send_literal();
			end
		end

		drain();
		if (fail_count == 0 && results_owed == 0) begin
			$display("string_literal_transcoder_core_tb: PASS");
		end else begin
			$display("string_literal_transcoder_core_tb: FAIL");
		end
		$finish;
	end

endmodule
